// ===== rtl/core/spgt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spgt_pkg;

    localparam int FUNC_W      = 3;
    localparam int GID_W       = 16;
    localparam int ADDR_W      = 56;
    localparam int COUNT_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int FILL_W      = 8;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - COUNT_W - STATUS_W;

    // request codes; 6 and 7 behave as a count read
    localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INCR  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DECR  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOGROUP   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_LISTFULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TABLEFULL = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SAT       = 3'd4;

    localparam logic signed [GID_W-1:0] GID_NONE = -16'sd1;
    localparam logic [COUNT_W-1:0]      COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic signed [GID_W-1:0] group;
        logic [COUNT_W-1:0]      members;
        logic [FILL_W-1:0]       fill;
    } slot_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_GSCAN,
        S_OPER,
        S_PSCAN,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/shared_page_group_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sharing-group table. One request in, one result out, one request in flight at a time.
// Group slots (id, member count, page fill) live in a NUM_GROUPS-entry memory and the page
// lists in a NUM_GROUPS x PAGES_PER_GROUP memory, both read through a registered port.
// Init and requests with group id -1 go straight to the result. Any other request looks
// up its group by reading the slot memory one entry a cycle, first match wins; add and
// query of a non-zero page then read the group's page list one entry a cycle, up to its
// fill count. The scan speed is set by the single read port of each memory. No clearing
// pass follows reset: slot entries are written at init and pages are read only below the
// group's fill count. A waiting result does not block the next request.
module shared_page_group_table_core
    import spgt_pkg::*;
#(
    parameter int NUM_GROUPS      = 64,
    parameter int PAGES_PER_GROUP = 128
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // func[2:0], gid[18:3], page_addr[74:19], zero pad[79:75]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // is_shared[0], member_count[8:1], status[11:9], zero pad[15:12]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int SLOT_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PG_W       = (PAGES_PER_GROUP > 1) ? $clog2(PAGES_PER_GROUP) : 1;
    localparam int PAGE_AW    = SLOT_W + PG_W;
    localparam int PAGE_DEPTH = NUM_GROUPS << PG_W;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]       func_reg, func_next;
    logic signed [GID_W-1:0] gid_reg, gid_next;
    logic [ADDR_W-1:0]       pa_reg, pa_next;

    logic [NUM_GROUPS-1:0]   used_reg, used_next;

    slot_entry_t             slot_mem [NUM_GROUPS];
    slot_entry_t             slot_rdata_reg;
    logic                    slot_re;
    logic [SLOT_W-1:0]       slot_raddr;
    logic                    slot_we;
    logic [SLOT_W-1:0]       slot_waddr;
    slot_entry_t             slot_wdata;

    logic [ADDR_W-1:0]       page_mem [PAGE_DEPTH];
    logic [ADDR_W-1:0]       page_rdata_reg;
    logic                    page_re;
    logic [PAGE_AW-1:0]      page_raddr;
    logic                    page_we;
    logic [PAGE_AW-1:0]      page_waddr;

    logic [SLOT_W:0]         gissue_reg, gissue_next;
    logic                    gchk_valid_reg, gchk_valid_next;
    logic [SLOT_W-1:0]       gchk_idx_reg, gchk_idx_next;
    logic [FILL_W-1:0]       pissue_reg, pissue_next;
    logic                    pchk_valid_reg, pchk_valid_next;

    logic [SLOT_W-1:0]       slot_idx_reg, slot_idx_next;
    logic [COUNT_W-1:0]      cur_members_reg, cur_members_next;
    logic [FILL_W-1:0]       cur_fill_reg, cur_fill_next;

    logic                    res_shared_reg, res_shared_next;
    logic [COUNT_W-1:0]      res_count_reg, res_count_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    g_issue, g_hit, p_issue, p_hit;
    logic                    out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign g_issue  = (gissue_reg < (SLOT_W + 1)'(NUM_GROUPS));
    assign g_hit    = gchk_valid_reg && used_reg[gchk_idx_reg]
                      && (slot_rdata_reg.group == gid_reg);
    // fill never exceeds the list length, so no clamp is needed
    assign p_issue  = (pissue_reg < cur_fill_reg);
    assign p_hit    = pchk_valid_reg && (page_rdata_reg == pa_reg);
    assign out_free = !m_valid_reg || m_tready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (func_reg == FN_INIT || gid_reg == GID_NONE)
                    state_next = S_RESULT;
                else
                    state_next = S_GSCAN;
            end
            S_GSCAN:
            begin
                if (g_hit)
                    state_next = S_OPER;
                else if (!g_issue)
                    state_next = S_RESULT;
            end
            S_OPER:
            begin
                if ((func_reg == FN_ADD || func_reg == FN_QUERY) && pa_reg != '0)
                    state_next = S_PSCAN;
                else
                    state_next = S_RESULT;
            end
            S_PSCAN:
            begin
                if (p_hit || !p_issue)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next        = func_reg;
        gid_next         = gid_reg;
        pa_next          = pa_reg;
        used_next        = used_reg;
        gissue_next      = gissue_reg;
        gchk_valid_next  = 1'b0;
        gchk_idx_next    = gchk_idx_reg;
        pissue_next      = pissue_reg;
        pchk_valid_next  = 1'b0;
        slot_idx_next    = slot_idx_reg;
        cur_members_next = cur_members_reg;
        cur_fill_next    = cur_fill_reg;
        res_shared_next  = res_shared_reg;
        res_count_next   = res_count_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        slot_re          = 1'b0;
        slot_raddr       = gissue_reg[SLOT_W-1:0];
        slot_we          = 1'b0;
        slot_waddr       = slot_idx_reg;
        slot_wdata       = '{group: gid_reg, members: cur_members_reg, fill: cur_fill_reg};
        page_re          = 1'b0;
        page_raddr       = {slot_idx_reg, pissue_reg[PG_W-1:0]};
        page_we          = 1'b0;
        page_waddr       = {slot_idx_reg, cur_fill_reg[PG_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tdata[2:0];
                    gid_next  = s_tdata[18:3];
                    pa_next   = s_tdata[74:19];
                end
            end
            S_DISPATCH:
            begin
                gissue_next     = '0;
                res_shared_next = 1'b0;
                res_count_next  = '0;
                res_status_next = STAT_NOGROUP;
                if (func_reg == FN_INIT && gid_reg != GID_NONE)
                begin
                    if (!free_found)
                    begin
                        res_status_next = STAT_TABLEFULL;
                    end
                    else
                    begin
                        res_status_next     = STAT_OK;
                        used_next[free_idx] = 1'b1;
                        slot_we             = 1'b1;
                        slot_waddr          = free_idx;
                        slot_wdata          = '{group: gid_reg, members: '0, fill: '0};
                    end
                end
            end
            S_GSCAN:
            begin
                // reads run one entry ahead of the compare
                slot_re         = g_issue;
                gchk_valid_next = g_issue;
                gchk_idx_next   = gissue_reg[SLOT_W-1:0];
                if (g_issue)
                    gissue_next = gissue_reg + 1'b1;
                if (g_hit)
                begin
                    slot_idx_next    = gchk_idx_reg;
                    cur_members_next = slot_rdata_reg.members;
                    cur_fill_next    = slot_rdata_reg.fill;
                end
            end
            S_OPER:
            begin
                pissue_next     = '0;
                res_shared_next = 1'b0;
                res_count_next  = cur_members_reg;
                res_status_next = STAT_OK;
                case (func_reg)
                    FN_INCR:
                    begin
                        if (cur_members_reg == COUNT_MAX)
                        begin
                            res_status_next = STAT_SAT;
                        end
                        else
                        begin
                            res_count_next     = cur_members_reg + 1'b1;
                            slot_we            = 1'b1;
                            slot_wdata.members = cur_members_reg + 1'b1;
                        end
                    end
                    FN_DECR:
                    begin
                        if (cur_members_reg == '0)
                        begin
                            res_status_next = STAT_SAT;
                        end
                        else
                        begin
                            res_count_next     = cur_members_reg - 1'b1;
                            slot_we            = 1'b1;
                            slot_wdata.members = cur_members_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        res_count_next = cur_members_reg;
                    end
                endcase
            end
            S_PSCAN:
            begin
                page_re         = p_issue;
                pchk_valid_next = p_issue;
                if (p_issue)
                    pissue_next = pissue_reg + 1'b1;
                if (p_hit)
                begin
                    res_shared_next = 1'b1;
                end
                else if (!p_issue && func_reg == FN_ADD)
                begin
                    if (cur_fill_reg >= FILL_W'(PAGES_PER_GROUP))
                    begin
                        res_status_next = STAT_LISTFULL;
                    end
                    else
                    begin
                        page_we         = 1'b1;
                        slot_we         = 1'b1;
                        slot_wdata.fill = cur_fill_reg + 1'b1;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{OUT_PAD_W{1'b0}}, res_status_reg, res_count_reg,
                                    res_shared_reg};
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            gchk_valid_reg <= 1'b0;
            pchk_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            gchk_valid_reg <= gchk_valid_next;
            pchk_valid_reg <= pchk_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        gid_reg         <= gid_next;
        pa_reg          <= pa_next;
        gissue_reg      <= gissue_next;
        gchk_idx_reg    <= gchk_idx_next;
        pissue_reg      <= pissue_next;
        slot_idx_reg    <= slot_idx_next;
        cur_members_reg <= cur_members_next;
        cur_fill_reg    <= cur_fill_next;
        res_shared_reg  <= res_shared_next;
        res_count_reg   <= res_count_next;
        res_status_reg  <= res_status_next;
        m_data_reg      <= m_data_next;
    end

    // slot memory; a write always lands before the next request can read it
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
            page_mem[page_waddr] <= pa_reg;
        if (page_re)
            page_rdata_reg <= page_mem[page_raddr];
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_page_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        page_we |-> (cur_fill_reg < FILL_W'(PAGES_PER_GROUP)))
        else $error("page written past the end of the group list");

    a_init_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_we && state_reg == S_DISPATCH) |-> !used_reg[free_idx])
        else $error("init claimed a slot already in use");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not handed to the output register");
`endif

endmodule

`default_nettype wire
